FILE: hdl/slpt_pkg.sv
// ----------------------------------------------------------------------------
// slpt_pkg
// Shared types and constants for the sonar line parser and distance table.
// ----------------------------------------------------------------------------
`default_nettype none

package slpt_pkg;

  // Field widths of the item channels.
  localparam int MODE_W     = 1;
  localparam int BYTE_W     = 8;
  localparam int READ_IDX_W = 11;
  localparam int KIND_W     = 2;
  localparam int STEP_W     = 16;
  localparam int DIST_OUT_W = 16;
  localparam int LATEST_W   = 11;

  // Default parameter values.
  localparam int DEF_ENTRIES    = 2048;
  localparam int DEF_DIST_WIDTH = 16;

  // Width that holds any table size in range, plus one bit for the compare.
  localparam int CMP_W = 17;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_BYTE = 1'b0;
  localparam logic [MODE_W-1:0] MODE_READ = 1'b1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_STORED   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd2;

  // Characters the parser recognises.
  localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  // Field numbers within a line.
  localparam logic [1:0] FIELD_STEP = 2'd0;
  localparam logic [1:0] FIELD_DIST = 2'd1;
  localparam logic [1:0] FIELD_MOVE = 2'd2;

  // A finished line as the parser reports it.
  typedef struct packed {
    logic                  fire;
    logic                  in_range;
    logic [STEP_W-1:0]     step;
    logic [DIST_OUT_W-1:0] distance;
    logic [LATEST_W-1:0]   latest;
  } slpt_line_t;

endpackage

`default_nettype wire

FILE: hdl/slpt_if.sv
// ----------------------------------------------------------------------------
// slpt_if
// Valid/ready channels for the request and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface slpt_in_if
  import slpt_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [MODE_W-1:0]     mode;
  logic [BYTE_W-1:0]     rx_byte;
  logic [READ_IDX_W-1:0] read_index;

  modport source (output valid, mode, rx_byte, read_index, input ready);
  modport sink   (input valid, mode, rx_byte, read_index, output ready);
endinterface

interface slpt_out_if
  import slpt_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [STEP_W-1:0]     step_index;
  logic [DIST_OUT_W-1:0] distance;
  logic [LATEST_W-1:0]   latest_step;

  modport source (output valid, kind, step_index, distance, latest_step, input ready);
  modport sink   (input valid, kind, step_index, distance, latest_step, output ready);
endinterface

`default_nettype wire

FILE: hdl/sonar_line_parser_table.sv
// ----------------------------------------------------------------------------
// sonar_line_parser_table
// Parses step,distance,move lines into a distance table and serves reads.
// ----------------------------------------------------------------------------
// One item is taken per cycle while request.ready is high, which the clearing
// pass and a stalled output hold low. A received byte updates the parser at
// once; a newline writes the distance into the table in the cycle the byte is
// taken, so a read that follows in the next cycle already sees it. A read item
// looks the entry up in the table memory, whose registered data joins the item
// from the first stage in the output register; line results take the same
// path. After reset the table is cleared one entry per cycle, so request.ready
// stays low until all ENTRIES entries (2048 by default) are clear.
// ----------------------------------------------------------------------------
`default_nettype none

module sonar_line_parser_table
  import slpt_pkg::*;
#(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int DIST_WIDTH = DEF_DIST_WIDTH
) (
  input wire logic   clk,
  input wire logic   rst,
  slpt_in_if.sink    request,
  slpt_out_if.source result
);

  localparam int               IDX_W     = $clog2(ENTRIES);
  localparam int               MEM_W     = (DIST_WIDTH < 16) ? DIST_WIDTH : 16;
  localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);

  slpt_line_t          line;
  logic [LATEST_W-1:0] last_step;
  logic                busy;
  logic [MEM_W-1:0]    rdata;

  logic                in_acc;
  logic                is_read;
  logic                byte_acc;
  logic [CMP_W-1:0]    rd_idx_ext;
  logic                out_load;

  // Stage between acceptance and the output register.
  logic                  s1_valid;
  logic                  s1_read;
  logic                  s1_rd_ok;
  logic [KIND_W-1:0]     s1_kind;
  logic [STEP_W-1:0]     s1_step;
  logic [DIST_OUT_W-1:0] s1_dist;
  logic [LATEST_W-1:0]   s1_latest;

  assign is_read    = (request.mode == MODE_READ);
  assign in_acc     = request.valid && request.ready;
  assign byte_acc   = in_acc && !is_read;
  assign rd_idx_ext = CMP_W'(request.read_index);

  assign out_load      = s1_valid && (!result.valid || result.ready);
  assign request.ready = !busy && (!s1_valid || !result.valid || result.ready);

  slpt_parser #(
    .ENTRIES    (ENTRIES),
    .DIST_WIDTH (DIST_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (byte_acc),
    .rx_byte   (request.rx_byte),
    .line      (line),
    .last_step (last_step)
  );

  slpt_table #(
    .ENTRIES (ENTRIES),
    .DATA_W  (MEM_W),
    .IDX_W   (IDX_W)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .we    (line.fire && line.in_range),
    .waddr (line.step[IDX_W-1:0]),
    .wdata (line.distance[MEM_W-1:0]),
    .re    (in_acc && is_read),
    .raddr (rd_idx_ext[IDX_W-1:0]),
    .rdata (rdata),
    .busy  (busy)
  );

  // First stage: hold the item while the table read is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= is_read || line.fire;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_read  <= is_read;
      s1_rd_ok <= rd_idx_ext < ENTRIES_C;
      if (is_read) begin
        s1_kind   <= KIND_READ;
        s1_step   <= STEP_W'(request.read_index);
        s1_dist   <= '0;
        s1_latest <= last_step;
      end else begin
        s1_kind   <= line.in_range ? KIND_STORED : KIND_REJECTED;
        s1_step   <= line.step;
        s1_dist   <= line.distance;
        s1_latest <= line.latest;
      end
    end
  end

  // Output register; read data joins here from the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.kind        <= s1_kind;
      result.step_index  <= s1_step;
      result.latest_step <= s1_latest;
      if (s1_read) begin
        result.distance <= s1_rd_ok ? DIST_OUT_W'(rdata) : '0;
      end else begin
        result.distance <= s1_dist;
      end
    end
  end

`ifndef SYNTHESIS
  // No item is taken while the table is being cleared.
  a_no_accept_while_clearing : assert property (
    @(posedge clk) disable iff (rst) busy |-> !request.ready
  ) else $error("item accepted during the clearing pass");

  // A read beyond the table returns zero.
  a_read_out_of_range_zero : assert property (
    @(posedge clk) disable iff (rst)
      (result.valid && (result.kind == KIND_READ) &&
       ({1'b0, result.step_index} >= ENTRIES_C)) |-> (result.distance == '0)
  ) else $error("out of range read returned non-zero distance");

  // A stored line becomes the latest step.
  a_stored_sets_latest : assert property (
    @(posedge clk) disable iff (rst)
      (result.valid && (result.kind == KIND_STORED)) |->
        (result.latest_step == result.step_index[LATEST_W-1:0])
  ) else $error("stored line does not match the latest step");

  // A finished line taken with its newline reaches the first stage as a line result.
  a_line_follows_newline : assert property (
    @(posedge clk) disable iff (rst)
      (byte_acc && line.fire) |=> s1_valid && !s1_read
  ) else $error("finished line lost between acceptance and first stage");
`endif

endmodule

`default_nettype wire

FILE: hdl/slpt_parser.sv
// ----------------------------------------------------------------------------
// slpt_parser
// Character decoder and field accumulators for step,distance,move lines.
// ----------------------------------------------------------------------------
`default_nettype none

module slpt_parser
  import slpt_pkg::*;
#(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int DIST_WIDTH = DEF_DIST_WIDTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic [BYTE_W-1:0]   rx_byte,
  output      slpt_line_t          line,
  output      logic [LATEST_W-1:0] last_step
);

  localparam logic [STEP_W-1:0] DIST_LIMIT =
    (DIST_WIDTH >= 16) ? {STEP_W{1'b1}} : STEP_W'((1 << DIST_WIDTH) - 1);
  localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);
  localparam int               PROD_W    = STEP_W + 4;

  logic                  synced;
  logic [1:0]            field_number;
  logic [STEP_W-1:0]     step_acc;
  logic [DIST_OUT_W-1:0] dist_acc;

  logic                  is_digit;
  logic [3:0]            digit;
  logic [PROD_W-1:0]     step_prod;
  logic [PROD_W-1:0]     dist_prod;
  logic [STEP_W-1:0]     step_sat;
  logic [DIST_OUT_W-1:0] dist_sat;
  logic                  in_range;
  logic [BYTE_W-1:0]     digit_off;

  // Digit decode and saturating decimal accumulation.
  assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
  assign digit_off = rx_byte - CHAR_ZERO;
  assign digit     = digit_off[3:0];
  assign step_prod = PROD_W'(step_acc) * PROD_W'(10) + PROD_W'(digit);
  assign dist_prod = PROD_W'(dist_acc) * PROD_W'(10) + PROD_W'(digit);
  assign step_sat  = (step_prod > PROD_W'({STEP_W{1'b1}})) ? {STEP_W{1'b1}}
                                                           : step_prod[STEP_W-1:0];
  assign dist_sat  = (dist_prod > PROD_W'(DIST_LIMIT)) ? DIST_LIMIT
                                                       : dist_prod[DIST_OUT_W-1:0];

  // The finished line as seen when its newline is taken.
  assign in_range      = {1'b0, step_acc} < ENTRIES_C;
  assign line.fire     = accept && synced && (rx_byte == CHAR_LF);
  assign line.in_range = in_range;
  assign line.step     = step_acc;
  assign line.distance = dist_acc;
  assign line.latest   = in_range ? step_acc[LATEST_W-1:0] : last_step;

  // Parser state update, one received character per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      synced       <= 1'b0;
      field_number <= FIELD_STEP;
      step_acc     <= '0;
      dist_acc     <= '0;
      last_step    <= '0;
    end else if (accept) begin
      if (!synced) begin
        if (rx_byte == CHAR_LF) begin
          synced <= 1'b1;
        end
      end else begin
        priority if (is_digit) begin
          if (field_number == FIELD_STEP) begin
            step_acc <= step_sat;
          end else if (field_number == FIELD_DIST) begin
            dist_acc <= dist_sat;
          end
        end else if (rx_byte == CHAR_COMMA) begin
          if (field_number != FIELD_MOVE) begin
            field_number <= field_number + 2'd1;
          end
        end else if (rx_byte == CHAR_LF) begin
          if (in_range) begin
            last_step <= step_acc[LATEST_W-1:0];
          end
          step_acc     <= '0;
          dist_acc     <= '0;
          field_number <= FIELD_STEP;
        end else if (rx_byte == CHAR_CR) begin
          // Carriage returns are dropped like any other character.
        end else begin
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/slpt_table.sv
// ----------------------------------------------------------------------------
// slpt_table
// Distance table memory with a clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module slpt_table
  import slpt_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES,
  parameter int DATA_W  = DEF_DIST_WIDTH,
  parameter int IDX_W   = $clog2(ENTRIES)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              we,
  input  wire logic [IDX_W-1:0]  waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [IDX_W-1:0]  raddr,
  output      logic [DATA_W-1:0] rdata,
  output      logic              busy
);

  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(ENTRIES - 1);

  logic [DATA_W-1:0] mem [ENTRIES];
  logic [IDX_W-1:0]  clr_addr;

  // Clearing sweep: one entry a cycle from the bottom up.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + IDX_W'(1);
      if (clr_addr == LAST_ADDR) begin
        busy <= 1'b0;
      end
    end
  end

  // Single write port, shared by the sweep and the line writes.
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
